### src/lpfd_pkg.sv
package lpfd_pkg;

	// Frame phase; the code doubles as the role reported for a byte
	typedef enum logic [2:0] {
		PH_CMD   = 3'd0,
		PH_TLEN  = 3'd1,
		PH_TOPIC = 3'd2,
		PH_PLEN  = 3'd3,
		PH_PAY   = 3'd4
	} phase_t;

	// Command byte codes on the wire
	localparam logic [7:0] CODE_SUB   = 8'h01;
	localparam logic [7:0] CODE_UNSUB = 8'h02;
	localparam logic [7:0] CODE_PUB   = 8'h03;

	// Frame kind as reported
	localparam logic [1:0] KIND_SUB   = 2'd0;
	localparam logic [1:0] KIND_UNSUB = 2'd1;
	localparam logic [1:0] KIND_PUB   = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	// One tagged item
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] role;
		logic [1:0] kind;
		logic       last;
	} tag_res_t;

	function automatic logic [1:0] kind_of(input logic [7:0] code);
		logic [1:0] k;
		unique case (code)
			CODE_SUB:   k = KIND_SUB;
			CODE_UNSUB: k = KIND_UNSUB;
			CODE_PUB:   k = KIND_PUB;
			default:    k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage

### src/lpfd_in_stage.sv
module lpfd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import lpfd_pkg::*;

	// Holds one item; refills in the same cycle it is drained
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

### src/lpfd_tag.sv
module lpfd_tag (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         byte_s1,
	output lpfd_pkg::tag_res_t res
);
	import lpfd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  kind_q, kind_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [23:0] shift_q, shift_d;
	logic [31:0] remain_q, remain_d;

	phase_t      role_v;
	logic        last_v;
	logic [1:0]  cnt_inc;
	logic [31:0] remain_dec;
	logic [15:0] tlen;
	logic [31:0] plen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CMD;
			kind_q   <= KIND_SUB;
			cnt_q    <= 2'd0;
			shift_q  <= 24'd0;
			remain_q <= 32'd0;
		end else if (take) begin
			phase_q  <= phase_d;
			kind_q   <= kind_d;
			cnt_q    <= cnt_d;
			shift_q  <= shift_d;
			remain_q <= remain_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		cnt_d      = cnt_q;
		shift_d    = shift_q;
		remain_d   = remain_q;
		role_v     = PH_CMD;
		last_v     = 1'b0;
		cnt_inc    = cnt_q + 2'd1;
		remain_dec = remain_q - 32'd1;
		tlen       = {shift_q[7:0], byte_s1};
		plen       = {shift_q, byte_s1};

		unique case (phase_q)
			PH_TLEN: begin
				role_v  = PH_TLEN;
				shift_d = {shift_q[15:0], byte_s1};
				cnt_d   = cnt_inc;
				if (cnt_inc >= 2'd2) begin
					cnt_d   = 2'd0;
					shift_d = 24'd0;
					if (tlen == 16'd0) begin
						// empty topic
						if (kind_q == KIND_PUB) begin
							phase_d = PH_PLEN;
						end else begin
							phase_d = PH_CMD;
							last_v  = 1'b1;
						end
					end else begin
						remain_d = {16'd0, tlen};
						phase_d  = PH_TOPIC;
					end
				end
			end
			PH_TOPIC: begin
				role_v   = PH_TOPIC;
				remain_d = remain_dec;
				if (remain_dec == 32'd0) begin
					if (kind_q == KIND_PUB) begin
						phase_d = PH_PLEN;
						cnt_d   = 2'd0;
						shift_d = 24'd0;
					end else begin
						phase_d = PH_CMD;
						last_v  = 1'b1;
					end
				end
			end
			PH_PLEN: begin
				role_v  = PH_PLEN;
				shift_d = {shift_q[15:0], byte_s1};
				if (cnt_q == 2'd3) begin
					cnt_d   = 2'd0;
					shift_d = 24'd0;
					if (plen == 32'd0) begin
						// empty payload
						phase_d = PH_CMD;
						last_v  = 1'b1;
					end else begin
						remain_d = plen;
						phase_d  = PH_PAY;
					end
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_PAY: begin
				role_v   = PH_PAY;
				remain_d = remain_dec;
				if (remain_dec == 32'd0) begin
					phase_d = PH_CMD;
					last_v  = 1'b1;
				end
			end
			default: begin
				role_v   = PH_CMD;
				kind_d   = kind_of(byte_s1);
				cnt_d    = 2'd0;
				shift_d  = 24'd0;
				remain_d = 32'd0;
				phase_d  = PH_TLEN;
			end
		endcase

		res.data = byte_s1;
		res.role = role_v;
		res.kind = kind_d;
		res.last = last_v;
	end

endmodule

### src/lpfd_out_reg.sv
module lpfd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  lpfd_pkg::tag_res_t res,
	output logic               can_load,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic [2:0]         role,
	output logic [1:0]         kind,
	output logic               frame_last
);
	import lpfd_pkg::*;

	logic     valid_q;
	tag_res_t res_q;

	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = res_q.data;
	assign role       = res_q.role;
	assign kind       = res_q.kind;
	assign frame_last = res_q.last;

endmodule

### src/length_prefixed_frame_deframer_core.sv
// Channel  | handshake             | payload
// ---------+-----------------------+----------------------------------
// input    | in_valid / in_ready   | in_byte
// output   | out_valid / out_ready | out_byte, role, kind, frame_last
//
// An accepted item passes the input register, then the tag logic into the
// result register, where it raises out_valid. One item per cycle sustained
// while the output is not stalled.
// The phase/count registers update only when an item moves from the input
// register into the result register, so a stalled output freezes framing.
// Reset (arst_n low) returns to "expect command byte" and empties both stages.
// in_ready stays high while the result register drains in the same cycle.
module length_prefixed_frame_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] role,
	output logic [1:0] kind,
	output logic       frame_last
);
	import lpfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       can_load;
	logic       take;
	tag_res_t   res;

	// an item leaves the input register when the result register has room
	assign take = valid_s1 && can_load;

	lpfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// phase tracking and tagging of the staged byte
	lpfd_tag u_tag (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	lpfd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take),
		.res        (res),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.role       (role),
		.kind       (kind),
		.frame_last (frame_last)
	);

`ifndef NO_ASSERTIONS
	// a command byte never closes a frame
	a_cmd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_last && role == PH_CMD))
		else $error("command byte marked as frame end");

	// payload phases only exist for publish frames
	a_pay_pub: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (role == PH_PLEN || role == PH_PAY) |-> kind == KIND_PUB)
		else $error("payload role on non-publish frame");

	// a byte handed to the result register shows up there next cycle
	a_take_out: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid)
		else $error("tagged item lost");

	// back-pressure only while the input register holds an item
	a_ready_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input blocked with empty stage");
`endif

endmodule
